[rtl/bcfs_pkg.sv]
// Shared types and constants of the bitmap first-fit free-run search block.
package bcfs_pkg;

  // Fixed field widths of the command and result beats.
  localparam int CMD_W   = 2;
  localparam int RUN_W   = 9;
  localparam int SLOT_W  = 8;
  localparam int START_W = 9;

  // Number of bitmap slots held by one cell of the search chain.
  localparam int CELL_BITS = 8;

  // Command codes; the fourth code has no meaning and does nothing.
  typedef enum logic [CMD_W-1:0] {
    CMD_FIND = 2'd0,
    CMD_USE  = 2'd1,
    CMD_FREE = 2'd2
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [RUN_W-1:0] run;
  } tok_t;

  // Slot write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              set;
    logic [SLOT_W-1:0] slot;
  } wr_t;

endpackage

[rtl/bitmap_contiguous_free_run_search_top.sv]
// Top level of the bitmap first-fit free-run search block.
//
// Keeps an occupancy map of SLOTS slots, all free after reset. Each command
// beat on the in_ channel (in_cmd, in_run_length, in_slot) gives exactly one
// result beat on the out_ channel (out_start_index, out_found).
// Find returns the lowest start of a run of at least in_run_length free
// slots, or SLOTS with out_found low; mark-used and mark-freed set or clear
// in_slot and return SLOTS with out_found low.
// The map lives in a chain of cells of eight slots each. A find sends a
// token down the chain, one cell per cycle; the token leaving the last cell
// carries the verdict. A zero-length find returns SLOTS with out_found low
// and, like a mark or an unused code, skips the chain. One command is worked
// on at a time: in_stall is high from accept until the result is moved into
// the output register. A result waiting under out_stall holds there while the
// next command is accepted and worked on. Synchronous reset (rst_n low)
// frees every slot and empties the chain and the output register.
module bitmap_contiguous_free_run_search_top
  import bcfs_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [RUN_W-1:0]   in_run_length,
  input  logic [SLOT_W-1:0]  in_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [START_W-1:0] out_start_index,
  output logic               out_found
);

  localparam int IW    = $clog2(SLOTS + 1);
  localparam int CELLS = (SLOTS + CELL_BITS - 1) / CELL_BITS;

  tok_t             tok  [CELLS+1];
  logic [IW-1:0]    cand [CELLS+1];
  logic [RUN_W-1:0] want;
  wr_t              wr;

  // Sequencer and result register.
  bcfs_ctrl #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_run_length   (in_run_length),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_start_index (out_start_index),
    .out_found       (out_found),
    .launch          (tok[0]),
    .want            (want),
    .wr              (wr),
    .tok_end         (tok[CELLS]),
    .cand_end        (cand[CELLS])
  );

  // A fresh token starts with an empty run at candidate slot zero.
  assign cand[0] = '0;

  // Chain of cells, lowest slots first.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    bcfs_cell #(
      .SLOTS (SLOTS),
      .IDX   (k),
      .IW    (IW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr     (wr),
      .want   (want),
      .tok_i  (tok[k]),
      .cand_i (cand[k]),
      .tok_o  (tok[k+1]),
      .cand_o (cand[k+1])
    );
  end

endmodule

[rtl/bcfs_cell.sv]
// One cell of the search chain: a group of bitmap slots and one token stage.
module bcfs_cell
  import bcfs_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int IDX   = 0,
  parameter int IW    = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_t              wr,
  input  logic [RUN_W-1:0] want,
  input  tok_t             tok_i,
  input  logic [IW-1:0]    cand_i,
  output tok_t             tok_o,
  output logic [IW-1:0]    cand_o
);

  logic [CELL_BITS-1:0] bits_r;
  logic [CELL_BITS-1:0] bits_nxt;
  tok_t                 tok_r;
  tok_t                 tok_nxt;
  logic [IW-1:0]        cand_r;
  logic [IW-1:0]        cand_nxt;

  // Apply a mark command to the slot of this cell that it addresses.
  always_comb begin
    bits_nxt = bits_r;
    for (int b = 0; b < CELL_BITS; b++) begin
      if (wr.en && (IDX * CELL_BITS + b < SLOTS) &&
          (int'(wr.slot) == IDX * CELL_BITS + b)) begin
        bits_nxt[b] = wr.set;
      end
    end
  end

  // Extend the running free count over this cell's slots; slots past the
  // end of the map count as used. The candidate start freezes on a hit.
  always_comb begin
    tok_nxt  = tok_i;
    cand_nxt = cand_i;
    for (int b = 0; b < CELL_BITS; b++) begin
      if (!tok_nxt.hit) begin
        if ((IDX * CELL_BITS + b >= SLOTS) || bits_r[b]) begin
          tok_nxt.run = '0;
          cand_nxt    = IW'(IDX * CELL_BITS + b + 1);
        end else begin
          tok_nxt.run = tok_nxt.run + RUN_W'(1);
          if (tok_nxt.run == want) begin
            tok_nxt.hit = 1'b1;
          end
        end
      end
    end
  end

  // The map and the token valid bit are reset; the token payload is not.
  always_ff @(posedge clk) begin
    tok_r.hit <= tok_nxt.hit;
    tok_r.run <= tok_nxt.run;
    cand_r    <= cand_nxt;
    if (!rst_n) begin
      bits_r       <= '0;
      tok_r.active <= 1'b0;
    end else begin
      bits_r       <= bits_nxt;
      tok_r.active <= tok_nxt.active;
    end
  end

  assign tok_o  = tok_r;
  assign cand_o = cand_r;

endmodule

[rtl/bcfs_ctrl.sv]
// Command sequencer: takes command beats, drives the chain and the result register.
module bcfs_ctrl
  import bcfs_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int IW    = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [RUN_W-1:0]   in_run_length,
  input  logic [SLOT_W-1:0]  in_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [START_W-1:0] out_start_index,
  output logic               out_found,
  output tok_t               launch,
  output logic [RUN_W-1:0]   want,
  output wr_t                wr,
  input  tok_t               tok_end,
  input  logic [IW-1:0]      cand_end
);

  state_t               state_r;
  state_t               state_nxt;
  logic [RUN_W-1:0]     want_r;
  logic [RUN_W-1:0]     want_nxt;
  logic [IW-1:0]        res_start_r;
  logic [IW-1:0]        res_start_nxt;
  logic                 res_found_r;
  logic                 res_found_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [START_W-1:0]   out_start_r;
  logic [START_W-1:0]   out_start_nxt;
  logic                 out_found_r;
  logic                 out_found_nxt;
  logic                 accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  // Next state, chain launch, slot writes and result handling.
  always_comb begin
    state_nxt     = state_r;
    want_nxt      = want_r;
    res_start_nxt = res_start_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_start_nxt = out_start_r;
    out_found_nxt = out_found_r;
    launch        = '0;
    wr.en         = 1'b0;
    wr.set        = 1'b0;
    wr.slot       = in_slot;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_start_nxt = IW'(SLOTS);
          res_found_nxt = 1'b0;
          state_nxt     = ST_RESULT;
          case (in_cmd)
            CMD_FIND: begin
              if (in_run_length != '0) begin
                launch.active = 1'b1;
                want_nxt      = in_run_length;
                state_nxt     = ST_SCAN;
              end
            end
            CMD_USE: begin
              wr.en  = 1'b1;
              wr.set = 1'b1;
            end
            CMD_FREE: begin
              wr.en  = 1'b1;
              wr.set = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The token leaving the last cell carries the verdict.
        if (tok_end.active) begin
          res_start_nxt = tok_end.hit ? cand_end : IW'(SLOTS);
          res_found_nxt = tok_end.hit;
          state_nxt     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = START_W'(res_start_r);
          out_found_nxt = res_found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r      <= want_nxt;
    res_start_r <= res_start_nxt;
    res_found_r <= res_found_nxt;
    out_start_r <= out_start_nxt;
    out_found_r <= out_found_nxt;
  end

  // The first cell works on the launch cycle, before the length is registered.
  assign want            = launch.active ? in_run_length : want_r;
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_start_index = out_start_r;
  assign out_found       = out_found_r;

endmodule
